/* src/dcop_pkg.sv */
// shared types, constants and the depth curve table of the column obstacle profile
package dcop_pkg;

    localparam int PIXEL_W     = 8;
    localparam int COLUMN_W    = 10;
    localparam int MIN_W       = 9;
    localparam int DIST_W      = 10;
    localparam int MAPDIM_W    = 11;
    localparam int COUNT_W     = 4;
    localparam int PLOT_W      = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    localparam int DEFAULT_MAX_COLUMNS = 1024;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam logic [MIN_W-1:0] EMPTY_MIN     = 9'd256;
    localparam logic [MIN_W-1:0] FAR_MIN       = 9'd255;
    localparam int               CENTER_COL    = 320;
    localparam int               DIST_OFFSET   = 10;

    localparam logic [MAPDIM_W-1:0] MAP_WIDTH_RST   = 11'd640;
    localparam logic [MAPDIM_W-1:0] MAP_HEIGHT_RST  = 11'd450;
    localparam logic [COLUMN_W-1:0] LEFT_MARGIN_RST = 10'd20;
    localparam logic [COLUMN_W-1:0] RIGHT_EDGE_RST  = 10'd610;
    localparam logic [COUNT_W-1:0]  HOLD_LIMIT_RST  = 4'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAP_WIDTH   = 3'd0,
        CFG_MAP_HEIGHT  = 3'd1,
        CFG_LEFT_MARGIN = 3'd2,
        CFG_RIGHT_EDGE  = 3'd3,
        CFG_HOLD_LIMIT  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [MAPDIM_W-1:0] map_width;
        logic [MAPDIM_W-1:0] map_height;
        logic [COLUMN_W-1:0] left_margin;
        logic [COLUMN_W-1:0] right_edge;
        logic [COUNT_W-1:0]  hold_limit;
    } cfg_t;

    // one finished column handed from front to back
    typedef struct packed {
        logic [MIN_W-1:0]    minimum;
        logic [COLUMN_W-1:0] column;
        logic                clear;
    } col_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        BACK_IDLE,
        BACK_MUL,
        BACK_SCALE,
        BACK_RECIP,
        BACK_FINISH
    } back_state_t;

    // quadratic depth model, entries 0..255; the model value at 256 equals entry 255
    localparam longint CURVE_DIV = 50000;

    typedef logic [DIST_W-1:0] curve_rom_t [256];

    function automatic curve_rom_t build_curve();
        curve_rom_t r;
        longint     num;
        longint     q;
        for (int p = 0; p < 256; p++)
        begin
            num = -168 * longint'(p) * longint'(p) + 105640 * longint'(p) - 50894;
            q = num / CURVE_DIV;
            if (q < 0)
            begin
                q = 0;
            end
            r[p] = q[DIST_W-1:0];
        end
        return r;
    endfunction

    localparam curve_rom_t DEPTH_CURVE = build_curve();

endpackage

/* src/dcop_pixel_if.sv */
// pixel stream channel
interface dcop_pixel_if import dcop_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PIXEL_W-1:0]  pixel;
    logic [COLUMN_W-1:0] column;
    logic                last_in_column;
    logic                frame_start;

    modport source (output valid, pixel, column, last_in_column, frame_start, input ready);
    modport sink   (input valid, pixel, column, last_in_column, frame_start, output ready);
endinterface

/* src/dcop_point_if.sv */
// obstacle point channel
interface dcop_point_if import dcop_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [COLUMN_W-1:0] map_x;
    logic [DIST_W-1:0]   map_y;

    modport source (output valid, map_x, map_y, input ready);
    modport sink   (input valid, map_x, map_y, output ready);
endinterface

/* src/dcop_cfg_if.sv */
// configuration write channel
interface dcop_cfg_if import dcop_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/dcop_front.sv */
// front end: per-pixel column minimum tracking and column record generation
module dcop_front import dcop_pkg::*; #(
    parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS
) (
    input  logic          clk,
    input  logic          rst_n,
    dcop_pixel_if.sink    pixels,
    input  queue_status_t q_status,
    output logic          push,
    output col_rec_t      push_rec
);

    logic [MIN_W-1:0]    min_reg, min_next;
    logic                clear_reg, clear_next;
    logic                accept;
    logic [MIN_W-1:0]    cur_min;
    logic [MIN_W-1:0]    new_min;
    logic [COLUMN_W-1:0] col_clamped;

    assign pixels.ready = !q_status.full;
    assign accept       = pixels.valid && pixels.ready;

    always_comb
    begin
        cur_min = pixels.frame_start ? EMPTY_MIN : min_reg;
        if ((pixels.pixel != '0) && ({1'b0, pixels.pixel} < cur_min))
        begin
            new_min = {1'b0, pixels.pixel};
        end
        else
        begin
            new_min = cur_min;
        end

        if (int'(pixels.column) > MAX_COLUMNS - 1)
        begin
            col_clamped = COLUMN_W'(MAX_COLUMNS - 1);
        end
        else
        begin
            col_clamped = pixels.column;
        end

        push             = accept && pixels.last_in_column;
        push_rec.minimum = new_min;
        push_rec.column  = col_clamped;
        push_rec.clear   = clear_reg || pixels.frame_start;

        min_next   = min_reg;
        clear_next = clear_reg;
        if (accept)
        begin
            if (pixels.last_in_column)
            begin
                min_next   = EMPTY_MIN;
                clear_next = 1'b0;
            end
            else
            begin
                min_next   = new_min;
                clear_next = clear_reg || pixels.frame_start;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= EMPTY_MIN;
            clear_reg <= 1'b0;
        end
        else
        begin
            min_reg   <= min_next;
            clear_reg <= clear_next;
        end
    end

endmodule

/* src/dcop_queue.sv */
// small column record queue between front and back
module dcop_queue import dcop_pkg::*; #(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  col_rec_t      push_rec,
    input  logic          pop,
    output col_rec_t      pop_rec,
    output queue_status_t status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    col_rec_t        entries [DEPTH];
    logic [AW-1:0]   wptr_reg, wptr_next;
    logic [AW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_rec      = entries[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

/* src/dcop_back.sv */
// back end: distance choice, map projection and obstacle point emission
module dcop_back import dcop_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  queue_status_t q_status,
    input  col_rec_t      rec,
    output logic          pop,
    dcop_point_if.source  points
);

    localparam int               PROD_W      = COLUMN_W + DIST_W + 3;
    localparam int               MAG_W       = 18;
    localparam int               RECIP_SHIFT = 37;
    localparam logic [23:0]      RECIP_MUL   = 24'd13743896;
    localparam int               WIDE_W      = PROD_W + 24;
    localparam logic [DIST_W-1:0] FAR_DIST   = DEPTH_CURVE[255];
    localparam logic [DIST_W-1:0] NEAR_DIST  = DEPTH_CURVE[0];

    back_state_t         state_reg, state_next;
    logic [DIST_W-1:0]   held_reg, held_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIST_W-1:0]   prev_d_reg, prev_d_next;
    logic [PLOT_W-1:0]   prev_x_reg, prev_x_next;
    logic                out_valid_reg, out_valid_next;
    logic [COLUMN_W-1:0] out_x_reg, out_x_next;
    logic [DIST_W-1:0]   out_y_reg, out_y_next;

    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [COLUMN_W-1:0] col_reg, col_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0]   mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [9:0]          q_reg, q_next;

    logic [DIST_W-1:0]   held_e;
    logic [COUNT_W-1:0]  cnt_e;
    logic [DIST_W-1:0]   sel_dist;
    logic [COUNT_W-1:0]  sel_cnt;
    logic [7:0]          rom_idx;
    logic signed [COLUMN_W+1:0] col_off;
    logic signed [DIST_W:0]     dist_off;
    logic [PROD_W-1:0]   abs_full;
    logic [MAG_W-1:0]    abs_v;
    logic [WIDE_W-1:0]   wide;
    logic signed [11:0]  q_signed;
    logic signed [11:0]  plot;
    logic [PLOT_W-1:0]   px;
    logic                emit;
    logic                out_free;

    assign points.valid = out_valid_reg;
    assign points.map_x = out_x_reg;
    assign points.map_y = out_y_reg;
    assign out_free     = !out_valid_reg || points.ready;

    // distance choice for the column at the head of the queue
    always_comb
    begin
        held_e  = rec.clear ? '0 : held_reg;
        cnt_e   = rec.clear ? '0 : cnt_reg;
        rom_idx = (rec.minimum == EMPTY_MIN) ? FAR_MIN[7:0] : rec.minimum[7:0];
        sel_cnt = cnt_e;
        priority if ((rec.minimum >= FAR_MIN) && (held_e != '0) && (cnt_e < cfg.hold_limit))
        begin
            sel_dist = held_e;
            sel_cnt  = cnt_e + 1'b1;
        end
        else if ((rec.column < cfg.left_margin) || (rec.column >= cfg.right_edge))
        begin
            sel_dist = FAR_DIST;
        end
        else if (cnt_e >= cfg.hold_limit)
        begin
            sel_dist = NEAR_DIST;
        end
        else
        begin
            sel_dist = DEPTH_CURVE[rom_idx];
            sel_cnt  = '0;
        end
    end

    // projection datapath
    always_comb
    begin
        col_off  = $signed({2'b00, col_reg}) - 12'sd320;
        dist_off = $signed({1'b0, dist_reg}) - 11'sd10;
        abs_full = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        abs_v    = abs_full[MAG_W-1:0];
        wide     = WIDE_W'(mag_reg) * WIDE_W'(RECIP_MUL);
        q_signed = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
        plot     = q_signed + 12'sd320;
        px       = plot[PLOT_W-1:0];
        emit     = ((prev_x_reg != px) || (dist_reg != prev_d_reg))
                   && (prev_d_reg != '0) && (prev_x_reg != '0)
                   && ({1'b0, dist_reg} < cfg.map_height)
                   && !plot[11] && (px < cfg.map_width);
    end

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        cnt_next       = cnt_reg;
        prev_d_next    = prev_d_reg;
        prev_x_next    = prev_x_reg;
        out_valid_next = out_valid_reg && !points.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        dist_next      = dist_reg;
        col_next       = col_reg;
        prod_next      = prod_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        q_next         = q_reg;
        pop            = 1'b0;

        unique case (state_reg)
            BACK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop       = 1'b1;
                    dist_next = sel_dist;
                    col_next  = rec.column;
                    cnt_next  = sel_cnt;
                    held_next = (rec.minimum != EMPTY_MIN) ? sel_dist : held_e;
                    if (rec.clear)
                    begin
                        prev_d_next = '0;
                        prev_x_next = '0;
                    end
                    state_next = BACK_MUL;
                end
            end
            BACK_MUL:
            begin
                prod_next  = PROD_W'(col_off) * PROD_W'(dist_off);
                state_next = BACK_SCALE;
            end
            BACK_SCALE:
            begin
                // times 21 as shift and add
                mag_next   = PROD_W'({abs_v, 4'b0000}) + PROD_W'({abs_v, 2'b00})
                             + PROD_W'(abs_v);
                neg_next   = prod_reg[PROD_W-1];
                state_next = BACK_RECIP;
            end
            BACK_RECIP:
            begin
                // divide by 10000 through the reciprocal
                q_next     = wide[RECIP_SHIFT+9:RECIP_SHIFT];
                state_next = BACK_FINISH;
            end
            BACK_FINISH:
            begin
                if (out_free)
                begin
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        out_x_next     = px[COLUMN_W-1:0];
                        out_y_next     = dist_reg;
                    end
                    prev_d_next = dist_reg;
                    prev_x_next = px;
                    state_next  = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            held_reg      <= '0;
            cnt_reg       <= '0;
            prev_d_reg    <= '0;
            prev_x_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            cnt_reg       <= cnt_next;
            prev_d_reg    <= prev_d_next;
            prev_x_reg    <= prev_x_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        dist_reg  <= dist_next;
        col_reg   <= col_next;
        prod_reg  <= prod_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        q_reg     <= q_next;
    end

endmodule

/* src/depth_column_obstacle_profile_top.sv */
// top level of the depth column obstacle profile block
//
// Pixels enter column by column; the front end takes one pixel per cycle
// while the queue is not full and keeps the running minimum of the column.
// Each column end leaves a record in a small queue (QUEUE_DEPTH columns, four
// by default). The back end takes one record at a time through these steps:
// distance choice from the depth curve table, the signed multiply of column
// and distance offsets, the scale by 21, the reciprocal multiply that divides
// by 10000, and the final map bounds test. So a pixel is taken every cycle
// as long as the back end keeps pace; a run of short columns fills the queue
// and pixel ready drops until the back end catches up. A point waits in an
// output register, and the back end only stalls at its last step when that
// register is still held by the sink. Configuration writes are always taken.
module depth_column_obstacle_profile_top import dcop_pkg::*; #(
    parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    dcop_pixel_if.sink    pixels,
    dcop_point_if.source  points,
    dcop_cfg_if.sink      cfg
);

    cfg_t          cfg_reg, cfg_next;
    queue_status_t q_status;
    logic          push;
    col_rec_t      push_rec;
    logic          pop;
    col_rec_t      pop_rec;

    // register file, writes land in the cycle after they are taken
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MAP_WIDTH:   cfg_next.map_width   = cfg.data;
                CFG_MAP_HEIGHT:  cfg_next.map_height  = cfg.data;
                CFG_LEFT_MARGIN: cfg_next.left_margin = cfg.data[COLUMN_W-1:0];
                CFG_RIGHT_EDGE:  cfg_next.right_edge  = cfg.data[COLUMN_W-1:0];
                CFG_HOLD_LIMIT:  cfg_next.hold_limit  = cfg.data[COUNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_width   <= MAP_WIDTH_RST;
            cfg_reg.map_height  <= MAP_HEIGHT_RST;
            cfg_reg.left_margin <= LEFT_MARGIN_RST;
            cfg_reg.right_edge  <= RIGHT_EDGE_RST;
            cfg_reg.hold_limit  <= HOLD_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // per-pixel minimum tracking, one record per column end
    dcop_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixels   (pixels),
        .q_status (q_status),
        .push     (push),
        .push_rec (push_rec)
    );

    // decouples pixel rate from the per-column sequencer
    dcop_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .status   (q_status)
    );

    // per-column distance choice, projection and point output
    dcop_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .rec      (pop_rec),
        .pop      (pop),
        .points   (points)
    );

endmodule

/* tb/tb_depth_column_obstacle_profile_top.sv */
// testbench for the depth column obstacle profile: directed table, random frames, predictor check
`timescale 1ns / 1ps

module tb_depth_column_obstacle_profile_top;
    import dcop_pkg::*;

    // run sizing
    localparam int ITEMS_TARGET     = 850;
    localparam int NUM_PHASES       = 8;
    localparam int DRAIN_CYCLES     = 64;       // queue of four columns through the back end, plus margin
    localparam int TIMEOUT_NS       = 5_000_000;
    localparam int MAX_REPORTS      = 10;

    // quadratic depth curve, distance = (a*p*p + b*p + c) / den, truncated, floored at zero
    localparam longint CURVE_SQ     = -168;
    localparam longint CURVE_LIN    = 105640;
    localparam longint CURVE_OFS    = -50894;
    localparam longint CURVE_DEN    = 50000;

    // projection scale, 21 / 10000
    localparam longint PLOT_NUM     = 21;
    localparam longint PLOT_DEN     = 10000;

    // register index with no register behind it
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel;
        logic [COLUMN_W-1:0] column;
        logic                last_in_column;
        logic                frame_start;
    } pixel_item_t;

    localparam int ITEM_W = $bits(pixel_item_t);

    typedef struct packed {
        logic [COLUMN_W-1:0] map_x;
        logic [DIST_W-1:0]   map_y;
    } point_t;

    // how a directed row gets its expectation
    typedef enum logic [1:0] {
        ROW_PREDICT,    // from the profile predictor
        ROW_NONE,       // typed in: no point
        ROW_POINT       // typed in: the given point
    } row_check_t;

    typedef struct packed {
        pixel_item_t item;
        row_check_t  how;
        point_t      pt;
    } directed_row_t;

    logic clk;
    logic rst_n;

    dcop_pixel_if pixel_ch();
    dcop_point_if point_ch();
    dcop_cfg_if   cfg_ch();

    depth_column_obstacle_profile_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixel_ch),
        .points (point_ch),
        .cfg    (cfg_ch)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // register copies seen by the predictor
    logic [MAPDIM_W-1:0] cfg_map_width   = MAP_WIDTH_RST;
    logic [MAPDIM_W-1:0] cfg_map_height  = MAP_HEIGHT_RST;
    logic [COLUMN_W-1:0] cfg_left_margin = LEFT_MARGIN_RST;
    logic [COLUMN_W-1:0] cfg_right_edge  = RIGHT_EDGE_RST;
    logic [COUNT_W-1:0]  cfg_hold_limit  = HOLD_LIMIT_RST;

    // running profile state of the predictor
    logic [MIN_W-1:0]    run_min    = EMPTY_MIN;
    logic [DIST_W-1:0]   held_dist  = '0;
    logic [COUNT_W-1:0]  empty_runs = '0;
    logic [DIST_W-1:0]   prev_dist  = '0;
    logic [PLOT_W-1:0]   prev_x     = '0;

    point_t        pending_points[$];   // obstacle points still owed by the block
    directed_row_t directed_rows[$];
    int            fed_items;
    int            bad_points;
    int            src_calm;
    int            sink_calm;
    int            sink_stall;

    // distance for a column minimum p, 0..256
    function automatic logic [DIST_W-1:0] depth_at(input int unsigned p);
        longint q;
        q = (CURVE_SQ * longint'(p) * longint'(p) + CURVE_LIN * longint'(p) + CURVE_OFS)
            / CURVE_DEN;
        if (q < 0)
        begin
            q = 0;
        end
        return q[DIST_W-1:0];
    endfunction

    // one pixel into the profile; at a column end decide on the obstacle point
    task automatic advance_profile(input pixel_item_t it, output bit hit, output point_t pt);
        logic [MIN_W-1:0]  col_min;
        logic [DIST_W-1:0] col_dist;
        longint            plot;
        logic [PLOT_W-1:0] x;
        hit = 1'b0;
        pt  = '0;
        if (it.frame_start)
        begin
            run_min    = EMPTY_MIN;
            held_dist  = '0;
            empty_runs = '0;
            prev_dist  = '0;
            prev_x     = '0;
        end
        if (it.pixel != 0 && it.pixel < run_min)
        begin
            run_min = {1'b0, it.pixel};
        end
        if (!it.last_in_column)
        begin
            return;
        end
        col_min = run_min;
        // priority: hold, margins, near after the hold ran out, curve
        if (col_min >= FAR_MIN && held_dist != 0 && empty_runs < cfg_hold_limit)
        begin
            col_dist   = held_dist;
            empty_runs = empty_runs + 1'b1;
        end
        else if (it.column < cfg_left_margin || it.column >= cfg_right_edge)
        begin
            col_dist = depth_at(255);
        end
        else if (empty_runs >= cfg_hold_limit)
        begin
            col_dist = depth_at(0);
        end
        else
        begin
            col_dist   = depth_at(32'(col_min));
            empty_runs = '0;
        end
        // exact signed product, truncated toward zero
        plot = (longint'(it.column) - CENTER_COL) * (longint'(col_dist) - DIST_OFFSET)
               * PLOT_NUM / PLOT_DEN + CENTER_COL;
        x    = plot[PLOT_W-1:0];
        hit  = (prev_x != x || col_dist != prev_dist) && prev_dist > 0 && prev_x > 0
               && col_dist < cfg_map_height && plot >= 0 && x < cfg_map_width;
        if (col_min != EMPTY_MIN)
        begin
            held_dist = col_dist;
        end
        prev_dist = col_dist;
        prev_x    = x;
        run_min   = EMPTY_MIN;
        pt.map_x  = x[COLUMN_W-1:0];
        pt.map_y  = col_dist;
    endtask

    // idle length: mostly none, some short, a few long, with calm stretches
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // pixel values leaning on no data, the far values and small minima
    function automatic logic [PIXEL_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            return '0;
        end
        if (r < 35)
        begin
            return 8'd255;
        end
        if (r < 40)
        begin
            return 8'd254;
        end
        if (r < 55)
        begin
            return PIXEL_W'($urandom_range(1, 20));
        end
        return PIXEL_W'($urandom_range(1, 255));
    endfunction

    // one pixel transaction, then the expectation it leaves
    task automatic push_pixel(input pixel_item_t it, input row_check_t how, input point_t typed);
        int     gap;
        bit     hit;
        point_t pt;
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid          <= 1'b1;
        pixel_ch.pixel          <= it.pixel;
        pixel_ch.column         <= it.column;
        pixel_ch.last_in_column <= it.last_in_column;
        pixel_ch.frame_start    <= it.frame_start;
        @(posedge clk);
        while (!pixel_ch.ready)
        begin
            @(posedge clk);
        end
        advance_profile(it, hit, pt);
        case (how)
            ROW_PREDICT:
            begin
                if (hit)
                begin
                    pending_points.push_back(pt);
                end
            end
            ROW_POINT:
            begin
                pending_points.push_back(typed);
            end
            default:
            begin
            end
        endcase
        fed_items++;
    endtask

    task automatic add_row(input logic [PIXEL_W-1:0] px, input logic [COLUMN_W-1:0] col,
                           input logic last, input logic start, input row_check_t how,
                           input logic [COLUMN_W-1:0] x, input logic [DIST_W-1:0] y);
        directed_row_t row;
        row.item = {px, col, last, start};
        row.how  = how;
        row.pt   = {x, y};
        directed_rows.push_back(row);
    endtask

    // one register write transaction; valid is left high for the next one
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_MAP_WIDTH:   cfg_map_width   = data;
            CFG_MAP_HEIGHT:  cfg_map_height  = data;
            CFG_LEFT_MARGIN: cfg_left_margin = data[COLUMN_W-1:0];
            CFG_RIGHT_EDGE:  cfg_right_edge  = data[COLUMN_W-1:0];
            CFG_HOLD_LIMIT:  cfg_hold_limit  = data[COUNT_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] width,
                                 input logic [CFG_DATA_W-1:0] height,
                                 input logic [CFG_DATA_W-1:0] left,
                                 input logic [CFG_DATA_W-1:0] right,
                                 input logic [CFG_DATA_W-1:0] hold,
                                 input bit touch_spare);
        write_reg(CFG_MAP_WIDTH, width);
        write_reg(CFG_MAP_HEIGHT, height);
        write_reg(CFG_LEFT_MARGIN, left);
        write_reg(CFG_RIGHT_EDGE, right);
        write_reg(CFG_HOLD_LIMIT, hold);
        if (touch_spare)
        begin
            write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom_range(0, 2047)));
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // stop feeding, collect every owed point, then let the back end go quiet
    task automatic drain();
        pixel_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one frame of columns with random content, plus some noise and broken columns
    task automatic run_frame();
        int          n_cols;
        int          col;
        int          step;
        int          sparse;
        int          n_pix;
        int          r;
        bit          empty_col;
        bit          first;
        pixel_item_t it;
        n_cols = $urandom_range(2, 16);
        col    = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 600);
        step   = $urandom_range(1, 60);
        sparse = $urandom_range(0, 60);
        first  = 1'b1;
        for (int c = 0; c < n_cols; c++)
        begin
            empty_col = $urandom_range(0, 99) < sparse;
            // short columns pile up in the column queue and push back on the stream
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                n_pix = 1;
            end
            else if (r < 30)
            begin
                n_pix = $urandom_range(2, 4);
            end
            else if (r < 95)
            begin
                n_pix = $urandom_range(5, 12);
            end
            else
            begin
                n_pix = $urandom_range(20, 40);
            end
            for (int p = 0; p < n_pix; p++)
            begin
                if ($urandom_range(0, 99) < 6)
                begin
                    it = ITEM_W'($urandom);     // noise: any field value
                end
                else
                begin
                    it.pixel          = empty_col ? '0 : pick_pixel();
                    it.column         = COLUMN_W'(col);
                    it.last_in_column = (p == n_pix - 1) && $urandom_range(0, 99) >= 3;
                    it.frame_start    = first;
                    first             = 1'b0;
                end
                push_pixel(it, ROW_PREDICT, '0);
            end
            col = (col + step) % 1024;
        end
    endtask

    // result sink with random stalls
    always @(posedge clk)
    begin
        if (sink_stall > 0)
        begin
            point_ch.ready <= 1'b0;
            sink_stall--;
        end
        else
        begin
            sink_stall = pick_gap(sink_calm);
            if (sink_stall > 0)
            begin
                point_ch.ready <= 1'b0;
                sink_stall--;
            end
            else
            begin
                point_ch.ready <= 1'b1;
            end
        end
    end

    // every point transaction against the oldest owed point
    always @(posedge clk)
    begin : point_check
        point_t want;
        if (rst_n && point_ch.valid && point_ch.ready)
        begin
            if (pending_points.size() == 0)
            begin
                bad_points++;
                if (bad_points <= MAX_REPORTS)
                begin
                    $display("%0t: point with none owed: x=%0d y=%0d",
                             $realtime, point_ch.map_x, point_ch.map_y);
                end
            end
            else
            begin
                want = pending_points.pop_front();
                if (point_ch.map_x !== want.map_x || point_ch.map_y !== want.map_y)
                begin
                    bad_points++;
                    if (bad_points <= MAX_REPORTS)
                    begin
                        $display("%0t: point mismatch: map_x exp %0d got %0d, map_y exp %0d got %0d",
                                 $realtime, want.map_x, point_ch.map_x,
                                 want.map_y, point_ch.map_y);
                    end
                end
            end
        end
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int per_phase;
        // known values on reset, pixel and register inputs from time zero
        rst_n                   <= 1'b0;
        pixel_ch.valid          <= 1'b0;
        pixel_ch.pixel          <= '0;
        pixel_ch.column         <= '0;
        pixel_ch.last_in_column <= 1'b0;
        pixel_ch.frame_start    <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= CFG_MAP_WIDTH;
        cfg_ch.data             <= '0;
        fed_items  = 0;
        bad_points = 0;
        src_calm   = 0;
        sink_calm  = 0;
        sink_stall = 0;

        // directed table: pixel, column, last, frame start, check, map_x, map_y
        // first column after reset: nothing to compare against yet
        add_row(8'd0,   10'd1,    1'b1, 1'b1, ROW_NONE,    10'd0,   10'd0);
        // far value, same point as before
        add_row(8'd255, 10'd2,    1'b1, 1'b0, ROW_NONE,    10'd0,   10'd0);
        // empty column reuses the held far distance
        add_row(8'd0,   10'd5,    1'b1, 1'b0, ROW_POINT,   10'd116, 10'd319);
        // right end of the scan projects past the map width
        add_row(8'd0,   10'd1023, 1'b1, 1'b0, ROW_NONE,    10'd0,   10'd0);
        // multi-pixel column, minimum of one through the curve at the center
        add_row(8'd200, 10'd320,  1'b0, 1'b0, ROW_NONE,    10'd0,   10'd0);
        add_row(8'd1,   10'd320,  1'b0, 1'b0, ROW_NONE,    10'd0,   10'd0);
        add_row(8'd255, 10'd320,  1'b1, 1'b0, ROW_PREDICT, 10'd0,   10'd0);
        // run of empty columns: held until the limit, then the near value
        for (int k = 0; k < 7; k++)
        begin
            add_row(8'd0, 10'(330 + k), 1'b1, 1'b0, ROW_PREDICT, 10'd0, 10'd0);
        end
        add_row(8'd255, 10'd400,  1'b1, 1'b0, ROW_PREDICT, 10'd0,   10'd0);
        add_row(8'd254, 10'd401,  1'b1, 1'b0, ROW_PREDICT, 10'd0,   10'd0);
        add_row(8'd128, 10'd0,    1'b1, 1'b0, ROW_PREDICT, 10'd0,   10'd0);
        // frame start on a column end clears the previous point
        add_row(8'd77,  10'd300,  1'b1, 1'b1, ROW_NONE,    10'd0,   10'd0);
        add_row(8'd254, 10'd301,  1'b0, 1'b0, ROW_NONE,    10'd0,   10'd0);
        add_row(8'd3,   10'd301,  1'b1, 1'b0, ROW_PREDICT, 10'd0,   10'd0);
        // both sides of each margin
        add_row(8'd128, 10'd610,  1'b1, 1'b0, ROW_PREDICT, 10'd0,   10'd0);
        add_row(8'd128, 10'd609,  1'b1, 1'b0, ROW_PREDICT, 10'd0,   10'd0);
        add_row(8'd128, 10'd20,   1'b1, 1'b0, ROW_PREDICT, 10'd0,   10'd0);
        add_row(8'd128, 10'd19,   1'b1, 1'b0, ROW_PREDICT, 10'd0,   10'd0);

        per_phase = (ITEMS_TARGET - directed_rows.size()) / NUM_PHASES;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain();
            end
            case (phase)
                0: apply_setting(MAP_WIDTH_RST, MAP_HEIGHT_RST, LEFT_MARGIN_RST,
                                 RIGHT_EDGE_RST, HOLD_LIMIT_RST, 1'b0);
                // widest map, no left margin, right margin only at the last column, longest hold
                1: apply_setting(11'd1024, 11'd1024, 11'd0, 11'd1023, 11'd15, 1'b0);
                // smallest map and margins covering everything: nothing gets out
                2: apply_setting(11'd1, 11'd1, 11'd1023, 11'd0, 11'd0, 1'b0);
                // inverted margins, zero hold limit
                3: apply_setting(CFG_DATA_W'($urandom_range(400, 1024)),
                                 CFG_DATA_W'($urandom_range(200, 1024)),
                                 11'd700, 11'd200, 11'd0, 1'b0);
                // oversized map registers; right edge data wraps to zero so all is far
                4: apply_setting(11'd2047, 11'd2047, 11'd0, 11'd1024, 11'd1, 1'b0);
                // typical values, and a write to an index with no register
                5: apply_setting(CFG_DATA_W'($urandom_range(200, 1024)),
                                 CFG_DATA_W'($urandom_range(50, 1024)),
                                 CFG_DATA_W'($urandom_range(0, 200)),
                                 CFG_DATA_W'($urandom_range(400, 1023)),
                                 CFG_DATA_W'($urandom_range(0, 15)), 1'b1);
                default: apply_setting(CFG_DATA_W'($urandom_range(200, 1024)),
                                       CFG_DATA_W'($urandom_range(50, 1024)),
                                       CFG_DATA_W'($urandom_range(0, 200)),
                                       CFG_DATA_W'($urandom_range(400, 1023)),
                                       CFG_DATA_W'($urandom_range(0, 15)), 1'b0);
            endcase
            if (phase == 0)
            begin
                foreach (directed_rows[i])
                begin
                    push_pixel(directed_rows[i].item, directed_rows[i].how, directed_rows[i].pt);
                end
            end
            while (fed_items < directed_rows.size() + (phase + 1) * per_phase)
            begin
                run_frame();
            end
        end

        drain();
        if (bad_points == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
src/dcop_pkg.sv
src/dcop_pixel_if.sv
src/dcop_point_if.sv
src/dcop_cfg_if.sv
src/dcop_front.sv
src/dcop_queue.sv
src/dcop_back.sv
src/depth_column_obstacle_profile_top.sv
tb/tb_depth_column_obstacle_profile_top.sv
